@@ rtl/tdps_pkg.sv @@
// ----------------------------------------------------------------------------
// tdps_pkg
// Shared types and constants of the tick-driven process scheduler.
// ----------------------------------------------------------------------------
package tdps_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int SLOT_BITS     = $clog2(MAX_PROCESSES);
    localparam int IDX_BITS      = SLOT_BITS + 1;
    localparam int TIME_BITS     = 16;
    localparam int TICK_BITS     = TIME_BITS + 1;

    localparam logic [IDX_BITS-1:0] NONE_SLOT = IDX_BITS'(MAX_PROCESSES);

    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_SJF  = 2'd1;
    localparam logic [1:0] MODE_RR   = 2'd2;
    localparam logic [1:0] MODE_BAD  = 2'd3;

    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_SLICE  = 2'd1;
    localparam logic [1:0] REG_TOTAL  = 2'd2;

    typedef enum logic [2:0] {
        EV_ARRIVED  = 3'd0,
        EV_SELECTED = 3'd1,
        EV_FINISHED = 3'd2,
        EV_IDLE     = 3'd3,
        EV_ACK      = 3'd4
    } t_event_kind;

    typedef struct packed {
        t_event_kind          kind;
        logic [3:0]           slot;
        logic [TICK_BITS-1:0] time_val;
        logic [TIME_BITS-1:0] rem;
        logic [TIME_BITS-1:0] wait_val;
        logic [TIME_BITS-1:0] tat;
        logic                 last;
    } t_event;

    typedef struct packed {
        logic        accept;
        logic        load;
        logic        charge;
        logic        scan_init;
        logic        scan_step;
        logic        select;
        logic        emit;
        t_event_kind kind;
        logic        flush;
        logic        tick_adv;
    } t_dp_cmd;

    typedef struct packed {
        logic can_emit;
        logic out_free;
        logic pend_valid;
        logic n_zero;
        logic arr_match;
        logic scan_last;
        logic fin_valid;
        logic sel_emit;
        logic cur_none;
    } t_dp_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CHARGE,
        S_SCAN,
        S_FINISH,
        S_SELECT,
        S_IDLE_EV,
        S_FLUSH
    } t_state;

endpackage

@@ rtl/tdps_in_if.sv @@
// ----------------------------------------------------------------------------
// tdps_in_if
// Input channel of the scheduler: load and tick items.
// ----------------------------------------------------------------------------
interface tdps_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [3:0]  slot;
    logic [15:0] arrival_time;
    logic [15:0] burst_length;

    modport source (output valid, op, slot, arrival_time, burst_length, input ready);
    modport sink (input valid, op, slot, arrival_time, burst_length, output ready);
endinterface

@@ rtl/tdps_out_if.sv @@
// ----------------------------------------------------------------------------
// tdps_out_if
// Output channel of the scheduler: event items.
// ----------------------------------------------------------------------------
interface tdps_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [3:0]  process_slot;
    logic [16:0] event_time;
    logic [15:0] remaining_burst;
    logic [15:0] wait_ticks;
    logic [15:0] turnaround_ticks;
    logic        last_of_run;

    modport source (output valid, event_kind, process_slot, event_time, remaining_burst,
                    wait_ticks, turnaround_ticks, last_of_run, input ready);
    modport sink (input valid, event_kind, process_slot, event_time, remaining_burst,
                  wait_ticks, turnaround_ticks, last_of_run, output ready);
endinterface

@@ rtl/tdps_ctrl.sv @@
// ----------------------------------------------------------------------------
// tdps_ctrl
// Sequencer that steps the datapath through load and tick processing.
// ----------------------------------------------------------------------------
module tdps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_op,
    output logic              o_in_ready,
    input  tdps_pkg::t_dp_stat i_stat,
    output tdps_pkg::t_dp_cmd  o_cmd
);

    tdps_pkg::t_state r_state, n_state;
    logic             r_is_tick, n_is_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tdps_pkg::S_IDLE;
            r_is_tick <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_tick <= n_is_tick;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_is_tick  = r_is_tick;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.kind = tdps_pkg::EV_IDLE;
        case (r_state)
            tdps_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_is_tick    = i_in_op;
                    n_state      = i_in_op ? tdps_pkg::S_CHARGE : tdps_pkg::S_LOAD;
                end
            end
            tdps_pkg::S_LOAD: begin
                o_cmd.kind = tdps_pkg::EV_ACK;
                if (i_stat.can_emit) begin
                    o_cmd.load = 1'b1;
                    o_cmd.emit = 1'b1;
                    n_state    = tdps_pkg::S_FLUSH;
                end
            end
            tdps_pkg::S_CHARGE: begin
                o_cmd.charge    = 1'b1;
                o_cmd.scan_init = 1'b1;
                n_state = i_stat.n_zero ? tdps_pkg::S_FINISH : tdps_pkg::S_SCAN;
            end
            tdps_pkg::S_SCAN: begin
                o_cmd.kind = tdps_pkg::EV_ARRIVED;
                if (!i_stat.arr_match || i_stat.can_emit) begin
                    o_cmd.scan_step = 1'b1;
                    o_cmd.emit      = i_stat.arr_match;
                    if (i_stat.scan_last) begin
                        n_state = tdps_pkg::S_FINISH;
                    end
                end
            end
            tdps_pkg::S_FINISH: begin
                o_cmd.kind = tdps_pkg::EV_FINISHED;
                if (!i_stat.fin_valid || i_stat.can_emit) begin
                    o_cmd.emit = i_stat.fin_valid;
                    n_state    = tdps_pkg::S_SELECT;
                end
            end
            tdps_pkg::S_SELECT: begin
                o_cmd.kind = tdps_pkg::EV_SELECTED;
                if (!i_stat.sel_emit || i_stat.can_emit) begin
                    o_cmd.select = 1'b1;
                    o_cmd.emit   = i_stat.sel_emit;
                    n_state      = tdps_pkg::S_IDLE_EV;
                end
            end
            tdps_pkg::S_IDLE_EV: begin
                o_cmd.kind = tdps_pkg::EV_IDLE;
                if (!i_stat.cur_none || i_stat.can_emit) begin
                    o_cmd.emit = i_stat.cur_none;
                    n_state    = tdps_pkg::S_FLUSH;
                end
            end
            tdps_pkg::S_FLUSH: begin
                if (!i_stat.pend_valid || i_stat.out_free) begin
                    o_cmd.flush    = i_stat.pend_valid;
                    o_cmd.tick_adv = r_is_tick;
                    n_state        = tdps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tdps_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/tdps_dp.sv @@
// ----------------------------------------------------------------------------
// tdps_dp
// Process table, scheduling state, scan logic and event output registers.
// ----------------------------------------------------------------------------
module tdps_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tdps_pkg::t_dp_cmd                   i_cmd,
    output tdps_pkg::t_dp_stat                  o_stat,
    input  logic [1:0]                          i_mode,
    input  logic [7:0]                          i_slice,
    input  logic [tdps_pkg::IDX_BITS-1:0]       i_n,
    input  logic [3:0]                          i_slot,
    input  logic [tdps_pkg::TIME_BITS-1:0]      i_arrival,
    input  logic [tdps_pkg::TIME_BITS-1:0]      i_burst,
    output logic                                o_valid,
    input  logic                                i_ready,
    output tdps_pkg::t_event                    o_event
);

    localparam int SB = tdps_pkg::SLOT_BITS;
    localparam int XB = tdps_pkg::IDX_BITS;
    localparam int TB = tdps_pkg::TIME_BITS;
    localparam int KB = tdps_pkg::TICK_BITS;

    logic [TB-1:0] r_arr   [tdps_pkg::MAX_PROCESSES];
    logic [TB-1:0] r_burst [tdps_pkg::MAX_PROCESSES];
    logic [TB-1:0] r_rem   [tdps_pkg::MAX_PROCESSES];

    logic [3:0]    r_slot;
    logic [TB-1:0] r_arr_in, r_burst_in;
    logic [KB-1:0] r_tick;
    logic [XB-1:0] r_cur, r_prev, r_fs;
    logic [7:0]    r_slice;
    logic [TB-1:0] r_ftat, r_fwait;
    logic [SB-1:0] r_idx;
    logic [XB-1:0] r_start;
    logic [XB-1:0] r_pick, r_any, r_ge;
    logic [TB-1:0] r_pick_rem, r_any_rem, r_ge_rem;
    logic          r_pv, r_ov;
    tdps_pkg::t_event r_pend, r_out;

    logic [SB-1:0] rd_addr;
    logic [TB-1:0] rd_rem, rd_arr, rd_burst, rem_dec;
    logic          cur_valid, elig, match;
    logic [7:0]    slice_inc;
    logic [KB-1:0] diff;
    logic [TB-1:0] tat, fwait;
    logic [XB-1:0] rr_pick, sel_slot;
    logic [TB-1:0] sel_rem;
    logic          sel_emit, out_free;
    tdps_pkg::t_event new_ev;
    tdps_pkg::t_event pend_last;

    assign rd_addr   = i_cmd.charge ? r_cur[SB-1:0] : r_idx;
    assign rd_rem    = r_rem[rd_addr];
    assign rd_arr    = r_arr[rd_addr];
    assign rd_burst  = r_burst[rd_addr];
    assign cur_valid = r_cur < i_n;
    assign rem_dec   = (rd_rem != '0) ? rd_rem - TB'(1) : '0;
    assign slice_inc = (r_slice == 8'hFF) ? r_slice : r_slice + 8'd1;
    assign elig      = ({1'b0, rd_arr} <= r_tick) && (rd_rem != '0);
    assign match     = ({1'b0, rd_arr} == r_tick);
    assign diff      = r_tick - {1'b0, rd_arr};

    always_comb begin
        if (r_tick > {1'b0, rd_arr}) begin
            tat = diff[KB-1] ? {TB{1'b1}} : diff[TB-1:0];
        end else begin
            tat = '0;
        end
        fwait = (tat > rd_burst) ? tat - rd_burst : '0;
    end

    always_comb begin
        rr_pick = (r_ge != tdps_pkg::NONE_SLOT) ? r_ge : r_any;
        if (i_mode == tdps_pkg::MODE_SJF) begin
            sel_slot = r_pick;
            sel_rem  = r_pick_rem;
            sel_emit = (r_pick != tdps_pkg::NONE_SLOT) && (r_pick != r_prev);
        end else begin
            sel_slot = rr_pick;
            sel_rem  = (r_ge != tdps_pkg::NONE_SLOT) ? r_ge_rem : r_any_rem;
            sel_emit = (r_cur == tdps_pkg::NONE_SLOT) && (i_n != '0) &&
                       (rr_pick != tdps_pkg::NONE_SLOT);
        end
    end

    always_comb begin
        new_ev          = '0;
        new_ev.kind     = i_cmd.kind;
        new_ev.time_val = r_tick;
        case (i_cmd.kind)
            tdps_pkg::EV_ACK:      new_ev.slot = r_slot;
            tdps_pkg::EV_ARRIVED:  new_ev.slot = 4'(r_idx);
            tdps_pkg::EV_FINISHED: begin
                new_ev.slot     = 4'(r_fs);
                new_ev.wait_val = r_fwait;
                new_ev.tat      = r_ftat;
            end
            tdps_pkg::EV_SELECTED: begin
                new_ev.slot = 4'(sel_slot);
                new_ev.rem  = sel_rem;
            end
            default: new_ev.slot = 4'd0;
        endcase
    end

    always_comb begin
        pend_last      = r_pend;
        pend_last.last = 1'b1;
    end

    assign out_free = !r_ov || i_ready;

    always_comb begin
        o_stat            = '0;
        o_stat.out_free   = out_free;
        o_stat.can_emit   = !r_pv || out_free;
        o_stat.pend_valid = r_pv;
        o_stat.n_zero     = (i_n == '0);
        o_stat.arr_match  = match;
        o_stat.scan_last  = ({1'b0, r_idx} == i_n - XB'(1));
        o_stat.fin_valid  = (r_fs != tdps_pkg::NONE_SLOT);
        o_stat.sel_emit   = sel_emit;
        o_stat.cur_none   = (r_cur == tdps_pkg::NONE_SLOT);
    end

    assign o_valid = r_ov;
    assign o_event = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_slot     <= i_slot;
            r_arr_in   <= i_arrival;
            r_burst_in <= i_burst;
        end
        if (i_cmd.load && ({1'b0, r_slot} < 5'(tdps_pkg::MAX_PROCESSES))) begin
            r_arr[r_slot[SB-1:0]]   <= r_arr_in;
            r_burst[r_slot[SB-1:0]] <= r_burst_in;
        end
        if (i_cmd.charge && cur_valid) begin
            r_ftat  <= tat;
            r_fwait <= fwait;
        end
        if (i_cmd.scan_init) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + SB'(1);
        end
        if (i_cmd.emit) begin
            r_pend <= new_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tdps_pkg::MAX_PROCESSES; i++) begin
                r_rem[i] <= '0;
            end
            r_tick     <= '0;
            r_cur      <= tdps_pkg::NONE_SLOT;
            r_prev     <= tdps_pkg::NONE_SLOT;
            r_fs       <= tdps_pkg::NONE_SLOT;
            r_slice    <= '0;
            r_start    <= '0;
            r_pick     <= tdps_pkg::NONE_SLOT;
            r_any      <= tdps_pkg::NONE_SLOT;
            r_ge       <= tdps_pkg::NONE_SLOT;
            r_pick_rem <= '0;
            r_any_rem  <= '0;
            r_ge_rem   <= '0;
            r_pv       <= 1'b0;
            r_ov       <= 1'b0;
            r_out      <= '0;
        end else begin
            if (i_cmd.load && ({1'b0, r_slot} < 5'(tdps_pkg::MAX_PROCESSES))) begin
                r_rem[r_slot[SB-1:0]] <= r_burst_in;
            end
            if (i_cmd.charge) begin
                r_pick <= tdps_pkg::NONE_SLOT;
                r_any  <= tdps_pkg::NONE_SLOT;
                r_ge   <= tdps_pkg::NONE_SLOT;
                r_fs   <= tdps_pkg::NONE_SLOT;
                if (cur_valid) begin
                    r_rem[rd_addr] <= rem_dec;
                    if (rem_dec == '0) begin
                        r_fs    <= r_cur;
                        r_prev  <= r_cur;
                        r_cur   <= tdps_pkg::NONE_SLOT;
                        r_slice <= '0;
                    end else if (i_mode == tdps_pkg::MODE_RR && slice_inc >= i_slice) begin
                        r_prev  <= r_cur;
                        r_cur   <= tdps_pkg::NONE_SLOT;
                        r_slice <= '0;
                    end else begin
                        r_slice <= slice_inc;
                    end
                end else begin
                    r_cur <= tdps_pkg::NONE_SLOT;
                end
                if (i_mode == tdps_pkg::MODE_RR && r_prev < i_n && !cur_valid) begin
                    r_start <= r_prev + XB'(1);
                end else if (i_mode == tdps_pkg::MODE_RR && cur_valid) begin
                    r_start <= r_cur + XB'(1);
                end else begin
                    r_start <= '0;
                end
            end
            if (i_cmd.scan_step && elig) begin
                if (r_pick == tdps_pkg::NONE_SLOT || rd_rem < r_pick_rem) begin
                    r_pick     <= {1'b0, r_idx};
                    r_pick_rem <= rd_rem;
                end
                if (r_any == tdps_pkg::NONE_SLOT) begin
                    r_any     <= {1'b0, r_idx};
                    r_any_rem <= rd_rem;
                end
                if (r_ge == tdps_pkg::NONE_SLOT && {1'b0, r_idx} >= r_start) begin
                    r_ge     <= {1'b0, r_idx};
                    r_ge_rem <= rd_rem;
                end
            end
            if (i_cmd.select) begin
                if (i_mode == tdps_pkg::MODE_SJF) begin
                    r_cur <= r_pick;
                    if (sel_emit) begin
                        r_prev  <= r_pick;
                        r_slice <= '0;
                    end
                end else if (sel_emit) begin
                    r_cur   <= rr_pick;
                    r_prev  <= rr_pick;
                    r_slice <= '0;
                end
            end
            if (i_cmd.tick_adv && !r_tick[KB-1]) begin
                r_tick <= r_tick + KB'(1);
            end
            if (i_cmd.emit) begin
                r_pv <= 1'b1;
                if (r_pv) begin
                    r_out <= r_pend;
                    r_ov  <= 1'b1;
                end else if (i_ready) begin
                    r_ov <= 1'b0;
                end
            end else if (i_cmd.flush) begin
                r_pv  <= 1'b0;
                r_out <= pend_last;
                r_ov  <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/tick_driven_process_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// tick_driven_process_scheduler_unit
// Process scheduler advanced one tick per tick item, with an APB register port.
// ----------------------------------------------------------------------------
// A load item returns one acknowledge. A tick item runs a scan over the
// process_total active slots (at most 16) that reads one table slot per cycle,
// waiting while an arrival event cannot yet be emitted, to report arrivals and
// find the next process; events are delivered in order, the final one of each
// item marked with last_of_run. Items are taken one at a time.
module tick_driven_process_scheduler_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tdps_in_if.sink      i_item,
    tdps_out_if.source   o_result,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [1:0]  r_mode;
    logic [7:0]  r_slice;
    logic [4:0]  r_total;
    logic [1:0]  mode_eff;
    logic [7:0]  slice_eff;
    logic [tdps_pkg::IDX_BITS-1:0] n_eff;
    logic        wr_en;

    tdps_pkg::t_dp_cmd  cmd;
    tdps_pkg::t_dp_stat stat;
    tdps_pkg::t_event   ev;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= tdps_pkg::MODE_FCFS;
            r_slice <= 8'd2;
            r_total <= '0;
        end else if (wr_en) begin
            case (paddr[3:2])
                tdps_pkg::REG_POLICY: r_mode  <= pwdata[1:0];
                tdps_pkg::REG_SLICE:  r_slice <= pwdata[7:0];
                tdps_pkg::REG_TOTAL:  r_total <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            tdps_pkg::REG_POLICY: prdata = {30'd0, r_mode};
            tdps_pkg::REG_SLICE:  prdata = {24'd0, r_slice};
            tdps_pkg::REG_TOTAL:  prdata = {27'd0, r_total};
            default:              prdata = '0;
        endcase
    end

    assign mode_eff  = (r_mode == tdps_pkg::MODE_BAD) ? tdps_pkg::MODE_FCFS : r_mode;
    assign slice_eff = (r_slice == 8'd0) ? 8'd1 : r_slice;
    assign n_eff     = (r_total > 5'(tdps_pkg::MAX_PROCESSES)) ?
                       tdps_pkg::IDX_BITS'(tdps_pkg::MAX_PROCESSES) :
                       tdps_pkg::IDX_BITS'(r_total);

    tdps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_op    (i_item.op),
        .o_in_ready (i_item.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tdps_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_mode    (mode_eff),
        .i_slice   (slice_eff),
        .i_n       (n_eff),
        .i_slot    (i_item.slot),
        .i_arrival (i_item.arrival_time),
        .i_burst   (i_item.burst_length),
        .o_valid   (o_result.valid),
        .i_ready   (o_result.ready),
        .o_event   (ev)
    );

    assign o_result.event_kind       = 3'(ev.kind);
    assign o_result.process_slot     = ev.slot;
    assign o_result.event_time       = ev.time_val;
    assign o_result.remaining_burst  = ev.rem;
    assign o_result.wait_ticks       = ev.wait_val;
    assign o_result.turnaround_ticks = ev.tat;
    assign o_result.last_of_run      = ev.last;

endmodule

@@ tb/tdps_checker.sv @@
// ----------------------------------------------------------------------------
// tdps_checker
// Watches the item channels and the register port of the scheduler, predicts
// every event item from its own copy of the process table and compares them.
// ----------------------------------------------------------------------------
module tdps_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdps_in_if          in_ch,
    tdps_out_if         out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NO_PROC = tdps_pkg::MAX_PROCESSES;

    logic [tdps_pkg::TIME_BITS-1:0] arrival_tab [tdps_pkg::MAX_PROCESSES];
    logic [tdps_pkg::TIME_BITS-1:0] burst_tab [tdps_pkg::MAX_PROCESSES];
    logic [tdps_pkg::TIME_BITS-1:0] left_tab [tdps_pkg::MAX_PROCESSES];
    logic [tdps_pkg::TICK_BITS-1:0] now_tick;
    int                   run_slot;
    int                   prior_slot;
    int                   slice_used;
    logic [1:0]           policy;
    logic [7:0]           quantum;
    logic [4:0]           active_total;
    tdps_pkg::t_event     event_q [$];

    assign o_pending = event_q.size();

    function automatic tdps_pkg::t_event make_event(tdps_pkg::t_event_kind kind, int slot,
                                                    int tval, int rem, int wt, int tat);
        tdps_pkg::t_event ev;
        ev.kind = kind;
        ev.slot = 4'(slot);
        ev.time_val = tdps_pkg::TICK_BITS'(tval);
        ev.rem = tdps_pkg::TIME_BITS'(rem);
        ev.wait_val = tdps_pkg::TIME_BITS'(wt);
        ev.tat = tdps_pkg::TIME_BITS'(tat);
        ev.last = 1'b0;
        return ev;
    endfunction

    task automatic clear_state();
        for (int i = 0; i < tdps_pkg::MAX_PROCESSES; i++) begin
            arrival_tab[i] = '0;
            burst_tab[i] = '0;
            left_tab[i] = '0;
        end
        now_tick = '0;
        run_slot = NO_PROC;
        prior_slot = NO_PROC;
        slice_used = 0;
        policy = tdps_pkg::MODE_FCFS;
        quantum = 8'd2;
        active_total = '0;
        event_q.delete();
    endtask

    function automatic bit ready_to_run(int i);
        return arrival_tab[i] <= now_tick && left_tab[i] != 0;
    endfunction

    task automatic advance_tick();
        int n, fin_slot, pick, start, s, k, tat, wt, t;
        n = (active_total > tdps_pkg::MAX_PROCESSES) ? tdps_pkg::MAX_PROCESSES : active_total;
        fin_slot = NO_PROC;
        pick = NO_PROC;
        k = 0;
        tat = 0;
        wt = 0;
        t = now_tick;
        if (run_slot >= n) run_slot = NO_PROC;
        if (run_slot != NO_PROC) begin
            if (left_tab[run_slot] != 0) left_tab[run_slot]--;
            if (slice_used < 255) slice_used++;
            if (left_tab[run_slot] == 0) begin
                fin_slot = run_slot;
                tat = (t > arrival_tab[run_slot]) ? t - arrival_tab[run_slot] : 0;
                if (tat > 65535) tat = 65535;
                wt = (tat > burst_tab[run_slot]) ? tat - burst_tab[run_slot] : 0;
                prior_slot = run_slot;
                run_slot = NO_PROC;
                slice_used = 0;
            end else if (policy == tdps_pkg::MODE_RR && slice_used >= quantum) begin
                prior_slot = run_slot;
                run_slot = NO_PROC;
                slice_used = 0;
            end
        end
        for (int i = 0; i < n; i++) begin
            if (arrival_tab[i] == t) begin
                event_q.push_back(make_event(tdps_pkg::EV_ARRIVED, i, t, 0, 0, 0));
                k++;
            end
        end
        if (fin_slot != NO_PROC) begin
            event_q.push_back(make_event(tdps_pkg::EV_FINISHED, fin_slot, t, 0, wt, tat));
            k++;
        end
        if (policy == tdps_pkg::MODE_SJF) begin
            for (int i = 0; i < n; i++) begin
                if (ready_to_run(i) && (pick == NO_PROC || left_tab[i] < left_tab[pick]))
                    pick = i;
            end
            run_slot = pick;
            if (pick != NO_PROC && pick != prior_slot) begin
                event_q.push_back(make_event(tdps_pkg::EV_SELECTED, pick, t, left_tab[pick],
                                             0, 0));
                k++;
                prior_slot = pick;
                slice_used = 0;
            end
        end else if (run_slot == NO_PROC && n > 0) begin
            start = (policy == tdps_pkg::MODE_RR && prior_slot < n) ? prior_slot + 1 : 0;
            for (int j = 0; j < n; j++) begin
                s = (start + j) % n;
                if (pick == NO_PROC && ready_to_run(s)) pick = s;
            end
            if (pick != NO_PROC) begin
                run_slot = pick;
                prior_slot = pick;
                slice_used = 0;
                event_q.push_back(make_event(tdps_pkg::EV_SELECTED, pick, t, left_tab[pick],
                                             0, 0));
                k++;
            end
        end
        if (run_slot == NO_PROC) begin
            event_q.push_back(make_event(tdps_pkg::EV_IDLE, 0, t, 0, 0, 0));
            k++;
        end
        if (now_tick <= 65535) now_tick++;
        if (k > 0) event_q[$].last = 1'b1;
    endtask

    task automatic compare_event();
        tdps_pkg::t_event ev;
        if (event_q.size() == 0) begin
            $error("unexpected event item: kind %0d slot %0d time %0d",
                   out_ch.event_kind, out_ch.process_slot, out_ch.event_time);
            o_errors++;
            return;
        end
        ev = event_q.pop_front();
        o_checked++;
        if (out_ch.event_kind !== ev.kind) begin
            $error("event_kind: expected %0d, got %0d", ev.kind, out_ch.event_kind);
            o_errors++;
        end
        if (out_ch.process_slot !== ev.slot) begin
            $error("process_slot: expected %0d, got %0d", ev.slot, out_ch.process_slot);
            o_errors++;
        end
        if (out_ch.event_time !== ev.time_val) begin
            $error("event_time: expected %0d, got %0d", ev.time_val, out_ch.event_time);
            o_errors++;
        end
        if (out_ch.remaining_burst !== ev.rem) begin
            $error("remaining_burst: expected %0d, got %0d", ev.rem, out_ch.remaining_burst);
            o_errors++;
        end
        if (out_ch.wait_ticks !== ev.wait_val) begin
            $error("wait_ticks: expected %0d, got %0d", ev.wait_val, out_ch.wait_ticks);
            o_errors++;
        end
        if (out_ch.turnaround_ticks !== ev.tat) begin
            $error("turnaround_ticks: expected %0d, got %0d", ev.tat, out_ch.turnaround_ticks);
            o_errors++;
        end
        if (out_ch.last_of_run !== ev.last) begin
            $error("last_of_run: expected %0d, got %0d", ev.last, out_ch.last_of_run);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_checked = 0;
        clear_state();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    tdps_pkg::REG_POLICY: policy = pwdata[1:0];
                    tdps_pkg::REG_SLICE:  quantum = pwdata[7:0];
                    tdps_pkg::REG_TOTAL:  active_total = pwdata[4:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.op == 1'b0) begin
                    arrival_tab[in_ch.slot] = in_ch.arrival_time;
                    burst_tab[in_ch.slot] = in_ch.burst_length;
                    left_tab[in_ch.slot] = in_ch.burst_length;
                    event_q.push_back(make_event(tdps_pkg::EV_ACK, in_ch.slot, now_tick,
                                                 0, 0, 0));
                    event_q[$].last = 1'b1;
                end else begin
                    advance_tick();
                end
            end
            if (out_ch.valid && out_ch.ready) compare_event();
        end
    end
endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives load and tick items and register writes into the process scheduler
// through every policy, with random gaps and stalls, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          checked;
    int          items_sent;
    int          ticks_sent;
    int          events_taken;
    bit          steady_rx;

    tdps_in_if  in_ch ();
    tdps_out_if out_ch ();

    tick_driven_process_scheduler_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tdps_checker checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_item(logic op, logic [3:0] slot, logic [15:0] arr, logic [15:0] burst);
        int gap;
        gap = steady_rx ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.slot <= slot;
        in_ch.arrival_time <= arr;
        in_ch.burst_length <= burst;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        if (op) ticks_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_ticks(int count, int slots);
        for (int i = 0; i < count; i++) begin
            if (slots > 0 && $urandom_range(0, 9) == 0)
                send_item(1'b0, 4'($urandom_range(0, slots - 1)),
                          16'(ticks_sent + $urandom_range(0, 3)), 16'($urandom_range(1, 6)));
            send_item(1'b1, 4'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic fill_table(int slots);
        int arr;
        logic [15:0] burst;
        arr = ticks_sent;
        for (int s = 0; s < slots; s++) begin
            arr += $urandom_range(0, 2);
            case ($urandom_range(0, 15))
                0:       burst = 16'd0;
                1, 2:    burst = 16'($urandom);
                default: burst = 16'($urandom_range(1, 5));
            endcase
            if ($urandom_range(0, 11) == 0) send_item(1'b0, 4'(s), 16'($urandom), burst);
            else send_item(1'b0, 4'(s), 16'(arr), burst);
        end
    endtask

    always begin
        int gap;
        gap = steady_rx ? 0 : $urandom_range(0, 12);
        if (events_taken == 60) begin
            out_ch.ready <= 1'b0;
            repeat (400) @(posedge i_clk);
        end else if (gap > 0) begin
            out_ch.ready <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        out_ch.ready <= 1'b1;
        do @(posedge i_clk); while (!(out_ch.valid === 1'b1));
        events_taken++;
    end

    initial begin
        logic [1:0]  modes [6];
        logic [7:0]  slices [6];
        logic [4:0]  totals [6];
        int          slots;
        modes = '{tdps_pkg::MODE_RR, tdps_pkg::MODE_RR, tdps_pkg::MODE_SJF,
                  tdps_pkg::MODE_FCFS, tdps_pkg::MODE_BAD, tdps_pkg::MODE_RR};
        slices = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd2, 8'd0};
        totals = '{5'd16, 5'd31, 5'd5, 5'd0, 5'd2, 5'd8};
        items_sent = 0;
        ticks_sent = 0;
        events_taken = 0;
        steady_rx = 1'b0;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.op <= 1'b0;
        in_ch.slot <= '0;
        in_ch.arrival_time <= '0;
        in_ch.burst_length <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        reg_write(tdps_pkg::REG_POLICY, 32'(tdps_pkg::MODE_FCFS));
        reg_write(tdps_pkg::REG_TOTAL, 32'd3);
        send_item(1'b0, 4'd0, 16'd0, 16'd2);
        send_item(1'b0, 4'd1, 16'hFFFF, 16'hFFFF);
        send_item(1'b0, 4'd2, 16'd1, 16'd0);
        send_item(1'b0, 4'd15, 16'd0, 16'd1);
        run_ticks(5, 0);

        reg_write(tdps_pkg::REG_POLICY, 32'(tdps_pkg::MODE_SJF));
        reg_write(tdps_pkg::REG_TOTAL, 32'd4);
        send_item(1'b0, 4'd0, 16'(ticks_sent), 16'd3);
        send_item(1'b0, 4'd1, 16'(ticks_sent), 16'd3);
        send_item(1'b0, 4'd2, 16'(ticks_sent + 1), 16'd1);
        send_item(1'b0, 4'd3, 16'(ticks_sent + 2), 16'd5);
        run_ticks(5, 0);
        reg_write(tdps_pkg::REG_TOTAL, 32'd1);
        run_ticks(3, 0);

        for (int p = 0; p < 6; p++) begin
            steady_rx = (p == 2);
            reg_write(tdps_pkg::REG_POLICY, 32'(modes[p]));
            reg_write(tdps_pkg::REG_SLICE, 32'(slices[p]));
            reg_write(tdps_pkg::REG_TOTAL, 32'(totals[p]));
            slots = (totals[p] > tdps_pkg::MAX_PROCESSES) ? tdps_pkg::MAX_PROCESSES : totals[p];
            fill_table(slots);
            run_ticks(12, slots);
        end
        steady_rx = 1'b0;

        drain();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d items (%0d ticks) across FCFS, SJF, round robin and the spare mode;",
                 items_sent, ticks_sent);
        $display("checked %0d event items including a long output stall.", checked);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

@@ tick_driven_process_scheduler_unit.f @@
rtl/tdps_pkg.sv
rtl/tdps_in_if.sv
rtl/tdps_out_if.sv
rtl/tdps_ctrl.sv
rtl/tdps_dp.sv
rtl/tick_driven_process_scheduler_unit.sv
tb/tdps_checker.sv
tb/tb.sv
